// ----- rtl/c3rb_pkg.sv -----
// ----------------------------------------------------------------------------
// c3rb_pkg
// shared constants, register codes and types for the 3x3 border-replicating
// convolution
// ----------------------------------------------------------------------------
package c3rb_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int PIXEL_BITS_DEF = 16;
	localparam int COEF_BITS_DEF  = 16;

	localparam int KREG_W    = 48;
	localparam int FW_W      = 11;
	localparam int FH_W      = 16;
	localparam int ROW_W     = 16;
	localparam int COL_OUT_W = 10;
	localparam int FILT_W    = 36;
	localparam int IDX_W     = 3;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = 2;
	localparam int LVL_W     = 3;
	localparam int NJOBS     = 4;

	typedef enum logic [IDX_W-1:0] {
		REG_KTOP    = 3'd0,
		REG_KMID    = 3'd1,
		REG_KBOT    = 3'd2,
		REG_FWIDTH  = 3'd3,
		REG_FHEIGHT = 3'd4
	} reg_idx_t;

	// what the back end has to produce for one pixel
	typedef struct packed {
		logic pass0;    // results for the row above
		logic pass1;    // results for the current row, which is the last one
		logic has_prev; // column to the left is complete
		logic last_col; // current column closes its row
		logic top_up;   // row above has a row above it
		logic top_mid;  // current row has a row above it
	} job_t;

	localparam int JOB_W = $bits(job_t);

	typedef struct packed {
		logic [KREG_W-1:0] top;
		logic [KREG_W-1:0] mid;
		logic [KREG_W-1:0] bot;
	} kernel_t;

endpackage

// ----- rtl/c3rb_if.sv -----
// ----------------------------------------------------------------------------
// c3rb interfaces
// pixel input channel and result output channel, valid/ready
// ----------------------------------------------------------------------------
interface c3rb_pix_if #(
	parameter int PIXEL_BITS = c3rb_pkg::PIXEL_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [PIXEL_BITS-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

interface c3rb_res_if;
	import c3rb_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [FILT_W-1:0] filtered;
	logic [ROW_W-1:0]         out_row;
	logic [COL_OUT_W-1:0]     out_col;
	logic                     frame_done;
	logic                     run_last;

	modport source (output valid, output filtered, output out_row, output out_col,
		output frame_done, output run_last, input ready);
	modport sink   (input valid, input filtered, input out_row, input out_col,
		input frame_done, input run_last, output ready);
endinterface

// ----- rtl/c3rb_queue.sv -----
// ----------------------------------------------------------------------------
// c3rb_queue
// small fifo between front and back, space reserved by the front
// ----------------------------------------------------------------------------
module c3rb_queue #(
	parameter int DATA_W = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic [DATA_W-1:0]        push_data,
	input  logic                     pop,
	output logic                     head_valid,
	output logic [DATA_W-1:0]        head_data,
	output logic [c3rb_pkg::LVL_W-1:0] level
);
	import c3rb_pkg::*;

	logic [DATA_W-1:0] mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0]  level_q;
	logic              do_pop;

	assign head_valid = level_q != '0;
	assign head_data  = mem_q[rd_ptr_q];
	assign level      = level_q;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !do_pop) begin
				level_q <= level_q + LVL_W'(1);
			end else if (!push && do_pop) begin
				level_q <= level_q - LVL_W'(1);
			end
		end
	end
endmodule

// ----- rtl/c3rb_front.sv -----
// ----------------------------------------------------------------------------
// c3rb_front
// takes pixels, keeps line stores and the 3x3 window, tags each pixel
// with the results it closes
// ----------------------------------------------------------------------------
module c3rb_front #(
	parameter int MAX_WIDTH  = c3rb_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = c3rb_pkg::PIXEL_BITS_DEF,
	parameter int CW         = 10,
	parameter int ENTRY_W    = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	c3rb_pix_if.sink                    pixels,
	input  logic [c3rb_pkg::FW_W-1:0]   frame_width,
	input  logic [c3rb_pkg::FH_W-1:0]   frame_height,
	input  logic [c3rb_pkg::LVL_W-1:0]  level,
	output logic                        push,
	output logic [ENTRY_W-1:0]          push_data
);
	import c3rb_pkg::*;

	localparam int PB   = PIXEL_BITS;
	localparam int WE_W = $clog2(MAX_WIDTH + 1);

	logic signed [PB-1:0] upper_mem [MAX_WIDTH];
	logic signed [PB-1:0] middle_mem [MAX_WIDTH];

	logic [CW-1:0]        col_q;
	logic [ROW_W-1:0]     row_q;
	logic                 accept;
	logic [WE_W-1:0]      fw_e;
	logic [FH_W-1:0]      fh_e;
	logic                 last_col;
	logic                 last_row;

	logic                 v_s1;
	logic signed [PB-1:0] px_s1;
	logic [CW-1:0]        col_s1;
	logic [ROW_W-1:0]     row_s1;
	logic                 last_col_s1;
	logic                 last_row_s1;
	logic signed [PB-1:0] rd_up_s1;
	logic signed [PB-1:0] rd_mid_s1;
	logic                 byp_s1;
	logic signed [PB-1:0] byp_up_s1;
	logic signed [PB-1:0] byp_mid_s1;

	logic signed [PB-1:0] up;
	logic signed [PB-1:0] mid;
	logic signed [PB-1:0] win_q [3][3];
	logic signed [PB-1:0] win_n [3][3];
	logic signed [PB-1:0] tap [3];
	job_t                 job;

	assign pixels.ready = ({1'b0, level} + (LVL_W+1)'(v_s1)) < (LVL_W+1)'(QDEPTH);
	assign accept       = pixels.valid && pixels.ready;

	always_comb begin
		if (32'(frame_width) > MAX_WIDTH) begin
			fw_e = WE_W'(MAX_WIDTH);
		end else if (frame_width == '0) begin
			fw_e = WE_W'(1);
		end else begin
			fw_e = WE_W'(frame_width);
		end
		fh_e     = (frame_height == '0) ? FH_W'(1) : frame_height;
		last_col = 32'(col_q) >= 32'(fw_e) - 32'd1;
		last_row = row_q >= fh_e - FH_W'(1);
	end

	// read side, data arrives with the item in s1
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1       <= pixels.pixel;
			col_s1      <= col_q;
			row_s1      <= row_q;
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
			rd_up_s1    <= upper_mem[col_q];
			rd_mid_s1   <= middle_mem[col_q];
			byp_s1      <= v_s1 && (col_s1 == col_q);
			byp_up_s1   <= mid;
			byp_mid_s1  <= px_s1;
		end
		if (v_s1) begin
			upper_mem[col_s1]  <= mid;
			middle_mem[col_s1] <= px_s1;
		end
	end

	always_comb begin
		up  = byp_s1 ? byp_up_s1 : rd_up_s1;
		mid = byp_s1 ? byp_mid_s1 : rd_mid_s1;
		tap[0] = up;
		tap[1] = mid;
		tap[2] = px_s1;
		for (int k = 0; k < 3; k++) begin
			if (col_s1 == '0) begin
				win_n[k][0] = tap[k];
				win_n[k][1] = tap[k];
			end else begin
				win_n[k][0] = win_q[k][1];
				win_n[k][1] = win_q[k][2];
			end
			win_n[k][2] = tap[k];
		end
		job.pass0    = row_s1 >= ROW_W'(1);
		job.pass1    = last_row_s1;
		job.has_prev = col_s1 != '0;
		job.last_col = last_col_s1;
		job.top_up   = row_s1 >= ROW_W'(2);
		job.top_mid  = row_s1 >= ROW_W'(1);
		push_data = '0;
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				push_data[(k*3+j)*PB +: PB] = win_n[k][j];
			end
		end
		push_data[9*PB +: CW]                = col_s1;
		push_data[9*PB+CW +: ROW_W]          = row_s1;
		push_data[9*PB+CW+ROW_W +: JOB_W]    = job;
	end

	assign push = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			col_q <= '0;
			row_q <= '0;
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[k][j] <= '0;
				end
			end
		end else begin
			v_s1 <= accept;
			if (v_s1) begin
				win_q <= win_n;
			end
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end
endmodule

// ----- rtl/c3rb_back.sv -----
// ----------------------------------------------------------------------------
// c3rb_back
// issues the results of each queued pixel one per cycle while the output is not
// stalled: select window, multiply, add rows, add total
// ----------------------------------------------------------------------------
module c3rb_back #(
	parameter int PIXEL_BITS = c3rb_pkg::PIXEL_BITS_DEF,
	parameter int COEF_BITS  = c3rb_pkg::COEF_BITS_DEF,
	parameter int CW         = 10,
	parameter int ENTRY_W    = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  logic [ENTRY_W-1:0]   head_data,
	output logic                 pop,
	input  c3rb_pkg::kernel_t    kernel,
	c3rb_res_if.source           results
);
	import c3rb_pkg::*;

	localparam int PB   = PIXEL_BITS;
	localparam int CB   = COEF_BITS;
	localparam int P    = PB + CB;
	localparam int RS_W = P + 2;
	localparam int TS_W = P + 4;

	logic signed [PB-1:0] win [3][3];
	logic [CW-1:0]        col;
	logic [ROW_W-1:0]     row;
	job_t                 job;
	logic [NJOBS-1:0]     mask;
	logic [NJOBS-1:0]     rem;
	logic [NJOBS-1:0]     pick;
	logic [NJOBS-1:0]     done_q;
	logic                 en;
	logic                 issue;
	logic                 last;
	logic                 sel_pass1;
	logic                 sel_lastc;
	logic [1:0]           rsel [3];
	logic [1:0]           csel [3];
	logic [KREG_W-1:0]    krow [3];
	logic signed [P-1:0]  prod [3][3];

	logic                 v_b1;
	logic signed [P-1:0]  prod_b1 [3][3];
	logic [ROW_W-1:0]     row_b1;
	logic [CW-1:0]        col_b1;
	logic                 done_b1;
	logic                 last_b1;

	logic                 v_b2;
	logic signed [RS_W-1:0] rsum_b2 [3];
	logic [ROW_W-1:0]     row_b2;
	logic [CW-1:0]        col_b2;
	logic                 done_b2;
	logic                 last_b2;

	logic                 o_valid_q;
	logic signed [TS_W-1:0] total;

	assign en = !o_valid_q || results.ready;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				win[k][j] = head_data[(k*3+j)*PB +: PB];
			end
		end
		col = head_data[9*PB +: CW];
		row = head_data[9*PB+CW +: ROW_W];
		job = job_t'(head_data[9*PB+CW+ROW_W +: JOB_W]);

		// bit order is the output order
		mask[0] = job.pass0 && job.has_prev;
		mask[1] = job.pass0 && job.last_col;
		mask[2] = job.pass1 && job.has_prev;
		mask[3] = job.pass1 && job.last_col;
		rem  = mask & ~done_q;
		pick = '0;
		for (int i = NJOBS - 1; i >= 0; i--) begin
			if (rem[i]) begin
				pick = '0;
				pick[i] = 1'b1;
			end
		end
		issue = en && head_valid && (rem != '0);
		last  = (rem & ~pick) == '0;
		pop   = en && head_valid && last;

		sel_pass1 = pick[2] || pick[3];
		sel_lastc = pick[1] || pick[3];
		if (sel_pass1) begin
			rsel[0] = job.top_mid ? 2'd1 : 2'd2;
			rsel[1] = 2'd2;
		end else begin
			rsel[0] = job.top_up ? 2'd0 : 2'd1;
			rsel[1] = 2'd1;
		end
		rsel[2] = 2'd2;
		if (sel_lastc) begin
			csel[0] = 2'd1;
			csel[1] = 2'd2;
		end else begin
			csel[0] = 2'd0;
			csel[1] = 2'd1;
		end
		csel[2] = 2'd2;

		krow[0] = kernel.top;
		krow[1] = kernel.mid;
		krow[2] = kernel.bot;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prod[i][j] = P'(win[rsel[i]][csel[j]])
					* P'($signed(krow[i][j*CB +: CB]));
			end
		end
		total = TS_W'(rsum_b2[0]) + TS_W'(rsum_b2[1]) + TS_W'(rsum_b2[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_b1 <= prod;
			row_b1  <= sel_pass1 ? row : row - ROW_W'(1);
			col_b1  <= sel_lastc ? col : col - CW'(1);
			last_b1 <= last;
			done_b1 <= last && job.pass1 && job.last_col;
			for (int i = 0; i < 3; i++) begin
				rsum_b2[i] <= RS_W'(prod_b1[i][0]) + RS_W'(prod_b1[i][1])
					+ RS_W'(prod_b1[i][2]);
			end
			row_b2  <= row_b1;
			col_b2  <= col_b1;
			done_b2 <= done_b1;
			last_b2 <= last_b1;
			results.filtered   <= FILT_W'(total);
			results.out_row    <= row_b2;
			results.out_col    <= COL_OUT_W'(col_b2);
			results.frame_done <= done_b2;
			results.run_last   <= last_b2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1      <= 1'b0;
			v_b2      <= 1'b0;
			o_valid_q <= 1'b0;
			done_q    <= '0;
		end else if (en) begin
			v_b1      <= issue;
			v_b2      <= v_b1;
			o_valid_q <= v_b2;
			if (pop) begin
				done_q <= '0;
			end else if (head_valid) begin
				done_q <= done_q | pick;
			end
		end
	end

	assign results.valid = o_valid_q;
endmodule

// ----- rtl/conv3x3_replicate_border.sv -----
// ----------------------------------------------------------------------------
// conv3x3_replicate_border
// streaming 3x3 convolution of a raster frame with edge pixels replicated
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per clock while the block is ready. The
// front end keeps two line stores (rows r-2 and r-1) and the 3x3 window; the
// back end issues one result per clock unless the result side stalls, through
// a multiply stage, a row sum stage and a final sum register. A pixel mid-row
// closes at most one result, up to two in the last row, and the pixel that
// ends a row up to two, or four in the last row, issued in turn with a
// four-entry queue between the halves absorbing the burst; the block sustains
// one pixel per clock while each closes at most one. The result for row r,
// column c leaves with pixel (r+1, c+1), or (r+1, c) at the row end; a
// one-row frame or the last row gives its own results right after those of
// the row above. Kernel rows hold three signed coefficients, left one in the
// low bits. Configure only while idle. Line stores need no clearing.
// ----------------------------------------------------------------------------
module conv3x3_replicate_border #(
	parameter int MAX_WIDTH  = c3rb_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = c3rb_pkg::PIXEL_BITS_DEF,
	parameter int COEF_BITS  = c3rb_pkg::COEF_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	c3rb_pix_if.sink                      pixels,
	c3rb_res_if.source                    results,
	input  logic                          wr_en,
	input  logic [c3rb_pkg::IDX_W-1:0]    wr_index,
	input  logic [c3rb_pkg::KREG_W-1:0]   wr_data
);
	import c3rb_pkg::*;

	// column counter and line store address width
	localparam int CW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ENTRY_W = 9 * PIXEL_BITS + CW + ROW_W + JOB_W;

	kernel_t             kernel_q;
	logic [FW_W-1:0]     frame_width_q;
	logic [FH_W-1:0]     frame_height_q;

	logic                push;
	logic [ENTRY_W-1:0]  push_data;
	logic                pop;
	logic                head_valid;
	logic [ENTRY_W-1:0]  head_data;
	logic [LVL_W-1:0]    level;

	// configuration registers, writes to unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q       <= '0;
			frame_width_q  <= FW_W'(1024);
			frame_height_q <= FH_W'(1);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_KTOP:    kernel_q.top   <= wr_data;
				REG_KMID:    kernel_q.mid   <= wr_data;
				REG_KBOT:    kernel_q.bot   <= wr_data;
				REG_FWIDTH:  frame_width_q  <= wr_data[FW_W-1:0];
				REG_FHEIGHT: frame_height_q <= wr_data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	// front: line stores, window, result tagging
	c3rb_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS),
		.CW         (CW),
		.ENTRY_W    (ENTRY_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixels       (pixels),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.level        (level),
		.push         (push),
		.push_data    (push_data)
	);

	// queue decouples pixel intake from result issue
	c3rb_queue #(
		.DATA_W (ENTRY_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data),
		.level      (level)
	);

	// back: one result per cycle unless the result side stalls, multiply and add pipeline
	c3rb_back #(
		.PIXEL_BITS (PIXEL_BITS),
		.COEF_BITS  (COEF_BITS),
		.CW         (CW),
		.ENTRY_W    (ENTRY_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.kernel     (kernel_q),
		.results    (results)
	);

	// queue space is reserved by the front, so it never overflows
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(level) <= QDEPTH)
		else $error("queue level beyond depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> 32'(level) < QDEPTH || pop)
		else $error("push into full queue");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.frame_done |-> results.run_last)
		else $error("frame end not on last result of its pixel");

endmodule

// ----- sim/conv3x3_replicate_border_tb.sv -----
// ----------------------------------------------------------------------------
// conv3x3_replicate_border_tb
// self-checking bench for the streaming 3x3 convolution with edge replication
// ----------------------------------------------------------------------------
// Frames of random and extreme pixels are streamed under random kernels and
// frame sizes. A scoreboard predicts every result as each pixel is accepted
// and checks results in order, field by field. Both channels idle at random,
// and once the result side holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module conv3x3_replicate_border_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import c3rb_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 12;
	localparam int HOLD_CYCLES    = 300;
	localparam int RANDOM_ITEMS   = 430;

	// one expected result
	typedef struct {
		logic [FILT_W-1:0]    filt;
		logic [ROW_W-1:0]     row;
		logic [COL_OUT_W-1:0] col;
		logic                 fdone;
		logic                 rlast;
	} conv_result_t;

	// predicts the convolution stream and checks results in arrival order
	class conv_scoreboard;
		logic [KREG_W-1:0] krow[3];
		int unsigned       fwidth, fheight;
		int                upper[MAX_WIDTH_DEF];
		int                middle[MAX_WIDTH_DEF];
		int                win[3][3];   // [row above-above, row above, current][c-2..c]
		int unsigned       col_cnt, row_cnt;
		conv_result_t      expected_q[$];
		int                errors;

		function new();
			krow = '{default: '0};
			fwidth = 1024;
			fheight = 1;
			win = '{default: 0};
			col_cnt = 0;
			row_cnt = 0;
			errors = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [KREG_W-1:0] d);
			case (idx)
				REG_KTOP:    krow[0] = d;
				REG_KMID:    krow[1] = d;
				REG_KBOT:    krow[2] = d;
				REG_FWIDTH:  fwidth = d[FW_W-1:0];
				REG_FHEIGHT: fheight = d[FH_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [FILT_W-1:0] sum9(int t, int m, int b, int x0, int x1, int x2);
			longint s;
			int     rsel[3];
			int     xsel[3];
			s = 0;
			rsel = '{t, m, b};
			xsel = '{x0, x1, x2};
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					s += longint'($signed(krow[i][j*16 +: 16])) * longint'(win[rsel[i]][xsel[j]]);
			return s[FILT_W-1:0];
		endfunction

		function void note_pixel(logic signed [15:0] px);
			int unsigned  w, h, c, r, orow;
			int           up, mid, v, t, m, b;
			bit           lcol, lrow;
			conv_result_t step_q[$];
			conv_result_t res;
			w = (fwidth == 0) ? 1 : (fwidth > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : fwidth);
			h = (fheight == 0) ? 1 : fheight;
			c = col_cnt;
			r = row_cnt;
			lcol = c >= w - 1;
			lrow = r >= h - 1;
			up = upper[c];
			mid = middle[c];
			upper[c] = mid;
			middle[c] = px;
			for (int k = 0; k < 3; k++) begin
				v = (k == 0) ? up : (k == 1) ? mid : int'(px);
				if (c == 0) begin
					win[k][0] = v;
					win[k][1] = v;
				end else begin
					win[k][0] = win[k][1];
					win[k][1] = win[k][2];
				end
				win[k][2] = v;
			end
			// first pass closes the row above, second the last row itself
			for (int pass = 0; pass < 2; pass++) begin
				if (pass == 0) begin
					if (r < 1) continue;
					t = (r >= 2) ? 0 : 1; m = 1; b = 2; orow = r - 1;
				end else begin
					if (!lrow) continue;
					t = (r >= 1) ? 1 : 2; m = 2; b = 2; orow = r;
				end
				res.row = orow[ROW_W-1:0];
				res.fdone = 0;
				res.rlast = 0;
				if (c >= 1) begin
					res.filt = sum9(t, m, b, 0, 1, 2);
					res.col = COL_OUT_W'(c - 1);
					step_q.push_back(res);
				end
				if (lcol) begin
					// right border replicated
					res.filt = sum9(t, m, b, 1, 2, 2);
					res.col = COL_OUT_W'(c);
					step_q.push_back(res);
				end
			end
			if (step_q.size() > 0) begin
				step_q[$].rlast = 1;
				step_q[$].fdone = lrow && lcol;
			end
			foreach (step_q[i]) expected_q.push_back(step_q[i]);
			if (lcol) begin
				col_cnt = 0;
				row_cnt = lrow ? 0 : ((r + 1) & 16'hffff);
			end else begin
				col_cnt = (c + 1) & 10'h3ff;
			end
		endfunction

		function void check_result(logic [FILT_W-1:0] filt, logic [ROW_W-1:0] row,
				logic [COL_OUT_W-1:0] col, logic fdone, logic rlast);
			conv_result_t e;
			if (expected_q.size() == 0) begin
				$error("unexpected result row %0d col %0d", row, col);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (filt !== e.filt) begin
				$error("filtered: expected %0d, got %0d", $signed(e.filt), $signed(filt));
				errors++;
			end
			if (row !== e.row) begin
				$error("out_row: expected %0d, got %0d", e.row, row);
				errors++;
			end
			if (col !== e.col) begin
				$error("out_col: expected %0d, got %0d", e.col, col);
				errors++;
			end
			if (fdone !== e.fdone) begin
				$error("frame_done: expected %0b, got %0b", e.fdone, fdone);
				errors++;
			end
			if (rlast !== e.rlast) begin
				$error("run_last: expected %0b, got %0b", e.rlast, rlast);
				errors++;
			end
		endfunction

		function bit at_frame_start();
			return col_cnt == 0 && row_cnt == 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_index;
	logic [KREG_W-1:0]  wr_data;

	c3rb_pix_if pix ();
	c3rb_res_if res ();

	conv3x3_replicate_border i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixels   (pix),
		.results  (res),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	conv_scoreboard conv_sb = new();

	int  items_sent;
	int  burst_left;
	bit  hold_request;
	int  hold_left;
	int  rx_cycle;
	int  idle_cycles;

	initial begin
		clk = 0;
		arst_n = 0;
		wr_en = 0;
		wr_index = '0;
		wr_data = '0;
		pix.valid = 0;
		pix.pixel = '0;
		res.ready = 0;
	end

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// receiver: own stall pattern, plus one long hold-off on request
	always @(posedge clk) begin
		rx_cycle++;
		if (hold_left > 0) begin
			hold_left--;
			res.ready <= 0;
		end else if (hold_request) begin
			hold_request = 0;
			hold_left = HOLD_CYCLES;
			res.ready <= 0;
		end else begin
			case ((rx_cycle >> 6) % 3)
				0: res.ready <= 1;                          // no stalls
				1: res.ready <= ($urandom_range(3, 0) != 0);
				default: res.ready <= rx_cycle[1];          // follows bit 1 of the cycle count
			endcase
		end
	end

	// results are stable between the edges, so check at the falling edge
	always @(negedge clk) begin
		if (arst_n && res.valid && res.ready)
			conv_sb.check_result(res.filtered, res.out_row, res.out_col,
				res.frame_done, res.run_last);
	end

	// watchdog on cycles without any traffic
	always @(negedge clk) begin
		if ((pix.valid && pix.ready) || (res.valid && res.ready) || wr_en || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// writes one register per edge; the caller lowers the enable afterwards
	task automatic set_reg(reg_idx_t idx, logic [KREG_W-1:0] d);
		wr_en <= 1;
		wr_index <= idx;
		wr_data <= d;
		conv_sb.write_reg(idx, d);
		@(posedge clk);
	endtask

	task automatic end_writes();
		wr_en <= 0;
		@(posedge clk);
	endtask

	// sender in bursts with random gaps between them
	task automatic send_pixel(logic signed [15:0] p);
		int  gap;
		bit  took;
		if (burst_left == 0) begin
			gap = $urandom_range(6, 0);
			burst_left = ($urandom_range(7, 0) == 0) ? 60 : $urandom_range(20, 1);
			if (gap > 0) begin
				pix.valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		pix.valid <= 1;
		pix.pixel <= p;
		do begin
			@(negedge clk);
			took = pix.ready;
			@(posedge clk);
		end while (!took);
		conv_sb.note_pixel(p);
		items_sent++;
	endtask

	function automatic logic signed [15:0] rand_pixel();
		case ($urandom_range(9, 0))
			0: return 16'sh7fff;
			1: return -16'sh8000;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [15:0] rand_coef();
		case ($urandom_range(7, 0))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0001;
			3: return 16'hffff;
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic stream_frame();
		do send_pixel(rand_pixel()); while (!conv_sb.at_frame_start());
	endtask

	// idle: every result in and the back end given time to settle
	task automatic drain();
		pix.valid <= 0;
		@(posedge clk);
		while (conv_sb.pending() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_kernels();
		set_reg(REG_KTOP, {rand_coef(), rand_coef(), rand_coef()});
		set_reg(REG_KMID, {rand_coef(), rand_coef(), rand_coef()});
		set_reg(REG_KBOT, {rand_coef(), rand_coef(), rand_coef()});
	endtask

	initial begin
		logic signed [15:0] edge_px[9];
		int                 fw, fh, phase;
		items_sent = 0;
		burst_left = 0;
		hold_request = 0;
		hold_left = 0;
		rx_cycle = 0;
		idle_cycles = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(posedge clk);

		// zero width and height act as one: single-pixel frames at the extremes
		set_reg(REG_KTOP, {16'h7fff, 16'h8000, 16'h7fff});
		set_reg(REG_KMID, {16'h8000, 16'h7fff, 16'h8000});
		set_reg(REG_KBOT, {16'h7fff, 16'h8000, 16'h7fff});
		set_reg(REG_FWIDTH, '0);
		set_reg(REG_FHEIGHT, '0);
		end_writes();
		send_pixel(16'sh7fff);
		send_pixel(-16'sh8000);
		send_pixel(16'sh0000);
		drain();

		// 3x3 frame with a checkerboard of extremes, worst-case sums
		set_reg(REG_FWIDTH, KREG_W'(3));
		set_reg(REG_FHEIGHT, KREG_W'(3));
		end_writes();
		edge_px = '{16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff,
			-16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff};
		foreach (edge_px[i]) send_pixel(edge_px[i]);
		drain();

		// single row: top, middle and bottom all from the same row
		set_reg(REG_FWIDTH, KREG_W'(4));
		set_reg(REG_FHEIGHT, KREG_W'(1));
		end_writes();
		repeat (4) send_pixel(rand_pixel());
		drain();

		// single column frame
		set_reg(REG_FWIDTH, KREG_W'(1));
		set_reg(REG_FHEIGHT, KREG_W'(3));
		end_writes();
		stream_frame();
		drain();

		// height lowered mid-frame: the current row becomes the last one
		set_reg(REG_FWIDTH, KREG_W'(3));
		set_reg(REG_FHEIGHT, KREG_W'(16'hffff));
		end_writes();
		repeat (7) send_pixel(rand_pixel());
		drain();
		set_reg(REG_FHEIGHT, KREG_W'(2));
		end_writes();
		stream_frame();
		drain();

		// width lowered mid-row: the current column closes the row
		set_reg(REG_FWIDTH, KREG_W'(8));
		set_reg(REG_FHEIGHT, KREG_W'(3));
		end_writes();
		repeat (5) send_pixel(rand_pixel());
		drain();
		set_reg(REG_FWIDTH, KREG_W'(3));
		end_writes();
		stream_frame();
		drain();

		// random frames, mostly small
		phase = 0;
		while (items_sent < RANDOM_ITEMS) begin
			random_kernels();
			fw = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
			fh = $urandom_range(6, 1);
			set_reg(REG_FWIDTH, KREG_W'(fw));
			set_reg(REG_FHEIGHT, KREG_W'(fh));
			end_writes();
			// long receiver hold-off while pixels keep coming
			if (phase == 3) hold_request = 1;
			repeat ($urandom_range(2, 1)) stream_frame();
			drain();
			phase++;
		end

		if (conv_sb.pending() != 0) begin
			$error("%0d expected results never arrived", conv_sb.pending());
			conv_sb.errors++;
		end
		if (conv_sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
